[design/awb_pkg.sv]
`timescale 1ns / 1ps
package awb_pkg;

  typedef enum logic [0:0] {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    REG_INV_A = 3'd0,
    REG_INV_B = 3'd1,
    REG_INV_C = 3'd2,
    REG_INV_D = 3'd3,
    REG_INV_E = 3'd4,
    REG_INV_F = 3'd5,
    REG_SRC_W = 3'd6,
    REG_SRC_H = 3'd7
  } reg_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [23:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  out_col;
    logic [6:0]  out_row;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
  } out_item_t;

  localparam logic [31:0] ONE_Q16 = 32'd65536;

  // Image RAM geometry and output window; the beat fields are sized for these.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int OUT_SIZE   = 112;

endpackage

[design/affine_warp_bilinear_sampler.sv]
`timescale 1ns / 1ps
// Channel | Signals                          | Beat
// in      | in_valid_i, in_stall_o, in_data_i  | write pixel or sample request
// out     | out_valid_o, out_stall_i, out_data_o | sampled pixel (8.8 RGB)
// cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// A write beat goes straight into the image RAM. A sample beat inside the
// output window holds the input through the transform sum, four neighbor
// reads from the single-port image RAM, a stage for the last read data, and
// one blend stage; the next beat enters after that, and the result then sits
// in the output register. Results leave through one output register; when it
// is full and stalled the blend stage holds and the input stalls too. Reset
// clears control and config registers; image RAM content is undefined until written.
module affine_warp_bilinear_sampler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  awb_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output awb_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  localparam int MaxWidth  = awb_pkg::MAX_WIDTH;
  localparam int MaxHeight = awb_pkg::MAX_HEIGHT;
  localparam int OutSize   = awb_pkg::OUT_SIZE;
  localparam int Xw = $clog2(MaxWidth);
  localparam int Yw = $clog2(MaxHeight);
  localparam int Aw = Xw + Yw;

  logic signed [31:0] inv_q [6];
  logic [8:0] srcw_q, srch_q;

  // Matrix and size registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q[0] <= 32'sd65536; inv_q[1] <= '0; inv_q[2] <= '0;
      inv_q[3] <= '0; inv_q[4] <= 32'sd65536; inv_q[5] <= '0;
      srcw_q <= 9'd256; srch_q <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (awb_pkg::reg_e'(cfg_index_i))
        awb_pkg::REG_SRC_W: srcw_q <= cfg_data_i[8:0];
        awb_pkg::REG_SRC_H: srch_q <= cfg_data_i[8:0];
        default: inv_q[cfg_index_i] <= cfg_data_i;
      endcase
    end
  end

  // Stage T: coordinate transform (multiplies registered before the add).
  logic        t_valid_q;
  logic [7:0]  t_x_q, t_y_q;
  logic signed [41:0] p_ax_q, p_by_q, p_dx_q, p_ey_q;
  logic signed [31:0] p_c_q, p_f_q;

  // Sequencer: 4 reads.
  logic        s_busy_q;
  logic [1:0]  s_cnt_q;
  logic signed [42:0] s_x0_q, s_y0_q;
  logic [15:0] s_dx_q, s_dy_q;
  logic [7:0]  s_col_q, s_row_q;
  logic [3:0]  s_inb_q;
  logic        s_rvld_q;
  logic [1:0]  s_rcnt_q;
  logic [23:0] n_q [3];
  logic        b_valid_q;
  logic [7:0]  b_col_q, b_row_q;

  logic out_full;
  assign out_full = out_valid_o && out_stall_i;
  logic in_acc, is_samp, wr_ok;
  // Hold input while a sample is in flight or the out register is blocked.
  assign in_stall_o = t_valid_q || s_busy_q || s_rvld_q || b_valid_q || out_full;
  assign in_acc = in_valid_i && !in_stall_o;
  assign is_samp = in_data_i.command == awb_pkg::CMD_SAMPLE;
  assign wr_ok = 32'(in_data_i.pos_x) < MaxWidth && 32'(in_data_i.pos_y) < MaxHeight;

  logic signed [42:0] sx, sy;
  assign sx = 43'(p_ax_q) + 43'(p_by_q) + 43'(p_c_q);
  assign sy = 43'(p_dx_q) + 43'(p_ey_q) + 43'(p_f_q);

  logic [9:0] w_eff, h_eff;
  assign w_eff = (32'(srcw_q) > MaxWidth)  ? 10'(MaxWidth)  : 10'(srcw_q);
  assign h_eff = (32'(srch_q) > MaxHeight) ? 10'(MaxHeight) : 10'(srch_q);

  logic signed [42:0] nx, ny;
  always_comb begin
    nx = s_x0_q + 43'(s_cnt_q[0]);
    ny = s_y0_q + 43'(s_cnt_q[1]);
  end
  logic nb_in;
  assign nb_in = nx >= 0 && ny >= 0 && nx < 43'(w_eff) && ny < 43'(h_eff);

  logic          ram_we;
  logic [Aw-1:0] ram_addr;
  logic [23:0]   ram_rdata;
  always_comb begin
    ram_we = in_acc && !is_samp && wr_ok;
    if (s_busy_q) begin
      ram_addr = {ny[Yw-1:0], nx[Xw-1:0]};
    end else begin
      ram_addr = {in_data_i.pos_y[Yw-1:0] , in_data_i.pos_x[Xw-1:0]};
    end
  end

  awb_ram #(.Width(24), .Depth(MaxWidth * MaxHeight)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(in_data_i.pixel_value), .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0; s_busy_q <= 1'b0; s_cnt_q <= '0;
      s_rvld_q <= 1'b0; s_rcnt_q <= '0; b_valid_q <= 1'b0;
      s_inb_q <= '0;
    end else begin
      t_valid_q <= in_acc && is_samp && 32'(in_data_i.pos_x) < OutSize
                   && 32'(in_data_i.pos_y) < OutSize;
      if (t_valid_q) begin
        s_busy_q <= 1'b1;
        s_cnt_q  <= '0;
      end else if (s_busy_q) begin
        s_cnt_q <= s_cnt_q + 2'd1;
        if (s_cnt_q == 2'd3) s_busy_q <= 1'b0;
      end
      s_rvld_q <= s_busy_q;
      s_rcnt_q <= s_cnt_q;
      if (s_busy_q) s_inb_q[s_cnt_q] <= nb_in;
      // Hold the blended beat while the output register is blocked.
      b_valid_q <= (s_rvld_q && s_rcnt_q == 2'd3) || (b_valid_q && out_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_x_q  <= in_data_i.pos_x;
      t_y_q  <= in_data_i.pos_y;
      p_ax_q <= inv_q[0] * $signed({1'b0, in_data_i.pos_x});
      p_by_q <= inv_q[1] * $signed({1'b0, in_data_i.pos_y});
      p_dx_q <= inv_q[3] * $signed({1'b0, in_data_i.pos_x});
      p_ey_q <= inv_q[4] * $signed({1'b0, in_data_i.pos_y});
      p_c_q  <= inv_q[2];
      p_f_q  <= inv_q[5];
    end
    if (t_valid_q) begin
      s_x0_q <= sx >>> 16; s_y0_q <= sy >>> 16;
      s_dx_q <= sx[15:0];  s_dy_q <= sy[15:0];
      s_col_q <= t_x_q;    s_row_q <= t_y_q;
    end
    if (s_rvld_q && s_rcnt_q != 2'd3) begin
      n_q[s_rcnt_q] <= s_inb_q[s_rcnt_q] ? ram_rdata : '0;
    end
    if (s_rvld_q && s_rcnt_q == 2'd3) begin
      b_col_q <= s_col_q; b_row_q <= s_row_q;
    end
  end

  logic [23:0] n3;
  assign n3 = s_inb_q[3] ? ram_rdata : '0;
  logic [15:0] lv [3];
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    localparam int Sh = 16 - 8 * ch;
    awb_blend u_blend (
      .clk_i, .a_i(n_q[0][Sh +: 8]), .b_i(n_q[1][Sh +: 8]),
      .c_i(n_q[2][Sh +: 8]), .d_i(n3[Sh +: 8]),
      .dx_i(s_dx_q), .dy_i(s_dy_q),
      .load_i(s_rvld_q && s_rcnt_q == 2'd3), .level_o(lv[ch])
    );
  end

  // Output register: load finished beat unless blocked, hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (b_valid_q && !out_full) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (b_valid_q && !out_full) begin
      out_data_o <= '{out_col: b_col_q[6:0], out_row: b_row_q[6:0],
                      red_level: lv[0], green_level: lv[1], blue_level: lv[2]};
    end
  end
endmodule

[design/awb_ram.sv]
`timescale 1ns / 1ps
module awb_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[design/awb_blend.sv]
`timescale 1ns / 1ps
// One channel: lerp along x, then along y, round to 8.8.
module awb_blend (
  input  logic        clk_i,
  input  logic [7:0]  a_i,
  input  logic [7:0]  b_i,
  input  logic [7:0]  c_i,
  input  logic [7:0]  d_i,
  input  logic [15:0] dx_i,
  input  logic [15:0] dy_i,
  input  logic        load_i,
  output logic [15:0] level_o
);
  logic [16:0] wx, wy;
  logic [24:0] top_q, bot_q;
  logic [24:0] top_d, bot_d;
  logic [41:0] top_y, bot_y;
  logic [42:0] v;
  logic [42:0] vr;

  assign wx = 17'(awb_pkg::ONE_Q16) - {1'b0, dx_i};
  assign wy = 17'(awb_pkg::ONE_Q16) - {1'b0, dy_i};
  assign top_d = 25'(a_i) * 25'(wx) + 25'(b_i) * 25'(dx_i);
  assign bot_d = 25'(c_i) * 25'(wx) + 25'(d_i) * 25'(dx_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

  assign top_y = top_q * wy;
  assign bot_y = bot_q * dy_i;
  assign v  = 43'(top_y) + 43'(bot_y);
  assign vr = v + 43'(1 << 23);
  assign level_o = vr[39:24];
endmodule
